/* src/matrix3_inverse_macros.svh */
// Assertion macros shared by the matrix inverse RTL.
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MI3_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MI3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mi3_pkg.sv */
// Shared constants, types and the product sequence table for the matrix inverse.
`default_nettype none
package mi3_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MW   = DATA_WIDTH + 1;           // multiplier operand width
  localparam int PW   = 2 * MW;                   // product width
  localparam int CW   = 2 * DATA_WIDTH + 1;       // cofactor width
  localparam int ACCW = DATA_WIDTH + CW + 2;      // determinant / accumulator width
  localparam int NW   = ACCW + 1;                 // divider remainder width
  localparam int NSH  = 2 * FRAC_BITS + 1;        // numerator scale shift
  localparam int QCW  = $clog2(DATA_WIDTH + 1);   // divider step counter width

  localparam logic [4:0] JOB_LAST = 5'd23;

  typedef enum logic [3:0] {
    ST_LOAD, ST_RD_A, ST_RD_B, ST_MUL, ST_ACC, ST_DET, ST_DIV_GO, ST_DIV_WAIT, ST_SING
  } state_t;

  typedef enum logic [1:0] {B_MAT, B_COF_LO, B_COF_HI} bsrc_t;

  typedef struct packed {
    logic [3:0] a_idx;
    logic [3:0] b_idx;
    bsrc_t      b_src;
    logic       sub;
    logic       shift;
    logic       first;
    logic       store;
    logic [3:0] cof_idx;
  } job_t;

  typedef struct packed {
    logic start;
    logic det_neg;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } div_sts_t;

  // adjugate cofactor k = m[a]*m[b] - m[c]*m[d]
  localparam logic [3:0] COF_IDX [9][4] = '{
    '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
  };

  // Products 0..17 build the cofactors, 18..23 the determinant (split cofactor halves).
  function automatic job_t job_info(input logic [4:0] j);
    job_t       r;
    logic [3:0] kk;
    logic [1:0] t;
    r  = '0;
    kk = j[4:1];
    t  = 2'd0;
    if (kk < 4'd9) begin
      r.cof_idx = kk;
      r.b_src   = B_MAT;
      if (!j[0]) begin
        r.a_idx = COF_IDX[kk][0];
        r.b_idx = COF_IDX[kk][1];
        r.first = 1'b1;
      end else begin
        r.a_idx = COF_IDX[kk][2];
        r.b_idx = COF_IDX[kk][3];
        r.sub   = 1'b1;
        r.store = 1'b1;
      end
    end else begin
      t         = 2'(kk - 4'd9);
      r.a_idx   = {2'b00, t};
      r.cof_idx = ({2'b00, t} << 1) + {2'b00, t};
      if (!j[0]) begin
        r.b_src = B_COF_LO;
        r.first = (t == 2'd0);
      end else begin
        r.b_src = B_COF_HI;
        r.shift = 1'b1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/mi3_div.sv */
// Bit-serial restoring divider: rounded, saturated cofactor / determinant.
`default_nettype none
module mi3_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mi3_pkg::div_ctl_t             ctl,
  input  wire logic signed [mi3_pkg::CW-1:0] cof,
  input  wire logic [mi3_pkg::ACCW-1:0]      dabs,
  output mi3_pkg::div_sts_t                  sts,
  output logic [mi3_pkg::DATA_WIDTH-1:0]     value
);
  import mi3_pkg::*;

  localparam logic [DATA_WIDTH-1:0] POS_LIM = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] NEG_LIM = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [NW-1:0]         rem_r;
  logic [DATA_WIDTH-1:0] nlo_r;
  logic [DATA_WIDTH-1:0] q_r;
  logic [QCW-1:0]        cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic                  neg_r;
  logic                  ovf_r;

  logic [CW-1:0] cmag;
  logic [NW-1:0] num;
  logic [NW-1:0] twod;
  logic [NW:0]   r2;
  logic [NW:0]   diff;
  logic          ge;
  logic          sat;

  assign cmag = cof[CW-1] ? CW'(-cof) : CW'(cof);
  assign num  = (NW'(cmag) << NSH) + NW'(dabs);
  assign twod = NW'(dabs) << 1;
  assign r2   = {rem_r, nlo_r[DATA_WIDTH-1]};
  assign diff = r2 - {1'b0, twod};
  assign ge   = (r2 >= {1'b0, twod});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= QCW'(DATA_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - QCW'(1);
        if (cnt_r == QCW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= num >> DATA_WIDTH;
      nlo_r <= num[DATA_WIDTH-1:0];
      q_r   <= '0;
      neg_r <= cof[CW-1] ^ ctl.det_neg;
      // quotient of 2^DATA_WIDTH or more always clips
      ovf_r <= ((num >> DATA_WIDTH) >= twod);
    end else if (busy_r) begin
      rem_r <= ge ? diff[NW-1:0] : r2[NW-1:0];
      nlo_r <= nlo_r << 1;
      q_r   <= {q_r[DATA_WIDTH-2:0], ge};
    end
  end

  always_comb begin
    if (neg_r) begin
      sat   = ovf_r || (q_r > NEG_LIM);
      value = sat ? NEG_LIM : DATA_WIDTH'(-q_r);
    end else begin
      sat   = ovf_r || q_r[DATA_WIDTH-1];
      value = sat ? POS_LIM : q_r;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.sat  = sat;

`include "matrix3_inverse_macros.svh"
  `MI3_ASSERT_NOW(a_done_idle, done_r, !busy_r, "divider done while busy")
  `MI3_ASSERT_NOW(a_fall_done, $fell(busy_r) && $past(rst_n), done_r, "divider stopped early")
  `MI3_ASSERT_NEXT(a_start_busy, ctl.start, busy_r, "divider did not start")

endmodule
`default_nettype wire

/* src/matrix3_inverse.sv */
// Top level: 3x3 fixed-point matrix inverse by adjugate and shared multiplier.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  input   | in_elem_value                           | transfer when start & !busy
//  result  | out_inv_value, out_row, out_col, flags  | out_valid, one cycle each
//
// Elements 1..8 are only stored. After the ninth, 24 products pass through the
// single 33x33 multiplier, each by way of the states RD_A, RD_B, MUL and ACC;
// ST_DET checks the determinant, then each of the nine results passes through the
// one-bit-per-cycle divider, and busy stays high from the ninth element until the
// last result is out. A singular matrix emits its nine zero results on consecutive
// cycles after the products. Synchronous active-low reset clears control; stored
// elements are undefined until loaded. The receiver cannot stall; busy holds off
// new elements.
`default_nettype none
module matrix3_inverse (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [mi3_pkg::DATA_WIDTH-1:0] in_elem_value,
  output logic                                     out_valid,
  output logic signed [mi3_pkg::DATA_WIDTH-1:0]    out_inv_value,
  output logic [1:0]                               out_row,
  output logic [1:0]                               out_col,
  output logic                                     out_singular,
  output logic                                     out_saturated,
  output logic                                     out_last_of_matrix
);
  import mi3_pkg::*;

  state_t state_r, state_nxt;

  logic [DATA_WIDTH-1:0] mstore_r [9];
  logic signed [CW-1:0]  cof_r [9];
  logic [3:0]            load_cnt_r;
  logic [4:0]            job_r;
  logic signed [MW-1:0]  opa_r;
  logic signed [MW-1:0]  opb_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [ACCW-1:0] acc_r;
  logic [ACCW-1:0]       dabs_r;
  logic                  det_neg_r;
  logic [3:0]            k_r;
  logic [1:0]            row_r;
  logic [1:0]            col_r;

  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_val_r;
  logic [1:0]            out_row_r;
  logic [1:0]            out_col_r;
  logic                  out_sing_r;
  logic                  out_sat_r;
  logic                  out_last_r;

  job_t                   job;
  logic [3:0]             rd_idx;
  logic [DATA_WIDTH-1:0]  rd_elem;
  logic [3:0]             cof_sel;
  logic signed [CW-1:0]   cof_rd;
  logic signed [MW-1:0]   opb_val;
  logic signed [ACCW-1:0] term;
  logic signed [ACCW-1:0] term_sh;
  logic signed [ACCW-1:0] acc_nxt;
  logic                   accept;
  logic                   emit;
  div_ctl_t               dctl;
  div_sts_t               dsts;
  logic [DATA_WIDTH-1:0]  div_value;

  assign job     = job_info(job_r);
  assign rd_idx  = (state_r == ST_RD_A) ? job.a_idx : job.b_idx;
  assign rd_elem = mstore_r[rd_idx];
  assign cof_sel = (state_r == ST_RD_B) ? job.cof_idx : k_r;
  assign cof_rd  = cof_r[cof_sel];
  assign accept  = start && (state_r == ST_LOAD);

  always_comb begin
    case (job.b_src)
      B_COF_LO: opb_val = $signed({1'b0, cof_rd[DATA_WIDTH-1:0]});
      B_COF_HI: opb_val = $signed(cof_rd[CW-1:DATA_WIDTH]);
      default:  opb_val = MW'($signed(rd_elem));
    endcase
  end

  assign term    = ACCW'(prod_r);
  assign term_sh = job.shift ? (term <<< DATA_WIDTH) : term;

  always_comb begin
    if (job.first) begin
      acc_nxt = job.sub ? -term_sh : term_sh;
    end else begin
      acc_nxt = job.sub ? (acc_r - term_sh) : (acc_r + term_sh);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    dctl.start = 1'b0;
    dctl.det_neg = det_neg_r;
    emit       = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (accept && load_cnt_r == 4'd8) state_nxt = ST_RD_A;
      end
      ST_RD_A: state_nxt = ST_RD_B;
      ST_RD_B: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC: begin
        state_nxt = (job_r == JOB_LAST) ? ST_DET : ST_RD_A;
      end
      ST_DET: begin
        state_nxt = (acc_r == '0) ? ST_SING : ST_DIV_GO;
      end
      ST_DIV_GO: begin
        dctl.start = 1'b1;
        state_nxt  = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (dsts.done) begin
          emit      = 1'b1;
          state_nxt = (k_r == 4'd8) ? ST_LOAD : ST_DIV_GO;
        end
      end
      ST_SING: begin
        emit = 1'b1;
        if (k_r == 4'd8) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (accept) begin
        load_cnt_r <= (load_cnt_r == 4'd8) ? 4'd0 : load_cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mstore_r[load_cnt_r] <= in_elem_value;
      job_r <= '0;
    end
    case (state_r)
      ST_RD_A: opa_r <= MW'($signed(rd_elem));
      ST_RD_B: opb_r <= opb_val;
      ST_MUL:  prod_r <= opa_r * opb_r;
      ST_ACC: begin
        acc_r <= acc_nxt;
        if (job.store) cof_r[job.cof_idx] <= acc_nxt[CW-1:0];
        job_r <= job_r + 5'd1;
      end
      ST_DET: begin
        det_neg_r <= acc_r[ACCW-1];
        dabs_r    <= acc_r[ACCW-1] ? ACCW'(-acc_r) : ACCW'(acc_r);
        k_r   <= '0;
        row_r <= '0;
        col_r <= '0;
      end
      default: ;
    endcase
    if (emit) begin
      out_val_r  <= (state_r == ST_SING) ? '0 : div_value;
      out_sat_r  <= (state_r == ST_SING) ? 1'b0 : dsts.sat;
      out_sing_r <= (state_r == ST_SING);
      out_row_r  <= row_r;
      out_col_r  <= col_r;
      out_last_r <= (k_r == 4'd8);
      k_r <= k_r + 4'd1;
      // advance row-major position
      if (col_r == 2'd2) begin
        col_r <= 2'd0;
        row_r <= row_r + 2'd1;
      end else begin
        col_r <= col_r + 2'd1;
      end
    end
  end

  mi3_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dctl),
    .cof   (cof_rd),
    .dabs  (dabs_r),
    .sts   (dsts),
    .value (div_value)
  );

  assign busy               = (state_r != ST_LOAD);
  assign out_valid          = out_valid_r;
  assign out_inv_value      = $signed(out_val_r);
  assign out_row            = out_row_r;
  assign out_col            = out_col_r;
  assign out_singular       = out_sing_r;
  assign out_saturated      = out_sat_r;
  assign out_last_of_matrix = out_last_r;

`include "matrix3_inverse_macros.svh"
  `MI3_ASSERT_NOW(a_last_pos, out_valid_r && out_last_r, out_row_r == 2'd2 && out_col_r == 2'd2, "last result not at row 2 col 2")
  `MI3_ASSERT_NOW(a_sing_zero, out_valid_r && out_sing_r, out_val_r == '0 && !out_sat_r, "singular result not zero")
  `MI3_ASSERT_NEXT(a_ninth_busy, accept && load_cnt_r == 4'd8, busy, "ninth element did not start the solve")
  `MI3_ASSERT_NOW(a_emit_idle_div, emit && state_r == ST_SING, !dsts.busy, "singular path overlaps divider")

endmodule
`default_nettype wire
